// ----- src/csd_pkg.sv -----
// Shared types and constants for the command/snapshot deframer.
// Used by every module under src; depends on nothing.
`default_nettype none
package csd_pkg;
   localparam logic [31:0] MAGIC = 32'h52485741;
   localparam logic [7:0] SNAP_OVERHEAD = 8'd32;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_SNAPSHOT = 2'd2;

   localparam logic [3:0] FC_PLAYER = 4'd0;
   localparam logic [3:0] FC_SEQ = 4'd4;
   localparam logic [3:0] FC_TICK = 4'd5;
   localparam logic [3:0] FC_PAYLOAD = 4'd6;
   localparam logic [3:0] FC_REV = 4'd7;
   localparam logic [3:0] FC_STATE = 4'd8;
   localparam logic [3:0] FC_NONE = 4'd9;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_SIZE = 2'd3;

   localparam logic [2:0] REG_KIND = 3'd0;
   localparam logic [2:0] REG_VERSION = 3'd1;
   localparam logic [2:0] REG_MAX_FRAME = 3'd2;
   localparam logic [2:0] REG_MAX_ID = 3'd3;
   localparam logic [2:0] REG_MAX_KIND = 3'd4;
   localparam logic [2:0] REG_MAX_PAYLOAD = 3'd5;
   localparam logic [2:0] REG_MAX_SNAP = 3'd6;

   typedef enum logic [11:0] {
      PH_PREFIX  = 12'b000000000001,
      PH_SLEN    = 12'b000000000010,
      PH_SBODY   = 12'b000000000100,
      PH_SEQ     = 12'b000000001000,
      PH_TICK    = 12'b000000010000,
      PH_PLEN    = 12'b000000100000,
      PH_PAYLOAD = 12'b000001000000,
      PH_REV     = 12'b000010000000,
      PH_STLEN   = 12'b000100000000,
      PH_STATE   = 12'b001000000000,
      PH_DONE    = 12'b010000000000,
      PH_BAD     = 12'b100000000000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  field_code;
      logic [63:0] value;
      logic        is_final;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [15:0] protocol_version;
      logic [23:0] max_frame_bytes;
      logic [15:0] max_id_length;
      logic [15:0] max_kind_length;
      logic [15:0] max_payload_bytes;
      logic [23:0] max_snapshot_bytes;
   } cfg_type;
endpackage
`default_nettype wire

// ----- src/csd_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on csd_pkg.
`default_nettype none
module csd_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           psel,
   input  wire logic           penable,
   input  wire logic           pwrite,
   input  wire logic [4:0]     paddr,
   input  wire logic [31:0]    pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output csd_pkg::cfg_type    cfg
);
   csd_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   assign idx = paddr[4:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            csd_pkg::REG_KIND:        cfg_in.frame_kind = pwdata[1:0];
            csd_pkg::REG_VERSION:     cfg_in.protocol_version = pwdata[15:0];
            csd_pkg::REG_MAX_FRAME:   cfg_in.max_frame_bytes = pwdata[23:0];
            csd_pkg::REG_MAX_ID:      cfg_in.max_id_length = pwdata[15:0];
            csd_pkg::REG_MAX_KIND:    cfg_in.max_kind_length = pwdata[15:0];
            csd_pkg::REG_MAX_PAYLOAD: cfg_in.max_payload_bytes = pwdata[15:0];
            csd_pkg::REG_MAX_SNAP:    cfg_in.max_snapshot_bytes = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         csd_pkg::REG_KIND:        prdata = {30'd0, cfg_ff.frame_kind};
         csd_pkg::REG_VERSION:     prdata = {16'd0, cfg_ff.protocol_version};
         csd_pkg::REG_MAX_FRAME:   prdata = {8'd0, cfg_ff.max_frame_bytes};
         csd_pkg::REG_MAX_ID:      prdata = {16'd0, cfg_ff.max_id_length};
         csd_pkg::REG_MAX_KIND:    prdata = {16'd0, cfg_ff.max_kind_length};
         csd_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, cfg_ff.max_payload_bytes};
         csd_pkg::REG_MAX_SNAP:    prdata = {8'd0, cfg_ff.max_snapshot_bytes};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{frame_kind: 2'd1, protocol_version: 16'd1,
                     max_frame_bytes: 24'd4096, max_id_length: 16'd64,
                     max_kind_length: 16'd64, max_payload_bytes: 16'd1024,
                     max_snapshot_bytes: 24'd1048576};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/csd_front.sv -----
// Front end: parses frame bytes through the phase machine, one per cycle while in_valid is high.
// Emits at most one classified result per byte. Depends on csd_pkg.
`default_nettype none
module csd_front #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  csd_pkg::req_type      in_req,
   input  csd_pkg::cfg_type      cfg,
   output logic                  out_valid,
   output csd_pkg::rsp_type      out_rsp
);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   csd_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_BITS-1:0] frame_count_ff, frame_count_in;
   logic count_over_ff, count_over_in;
   logic [COUNT_BITS-1:0] field_count_ff, field_count_in;
   logic [COUNT_BITS-1:0] field_length_ff, field_length_in;
   logic [63:0] word_ff, word_in;
   logic [1:0] sidx_ff, sidx_in;
   logic corrupt_ff, corrupt_in, invalid_ff, invalid_in;

   logic [7:0] b;
   logic [63:0] gw;
   logic [COUNT_BITS-1:0] fc1;
   logic emit, ok;
   logic [3:0] code;
   logic [63:0] val;
   logic [7:0] expb;
   logic [15:0] lim;
   logic [24:0] limit;
   logic [1:0] st;

   assign b = in_req.data_byte;
   assign fc1 = field_count_ff + 1'b1;

   always_comb begin
      gw = word_ff;
      case (field_count_ff[2:0])
         3'd0: gw[7:0] = b;
         3'd1: gw[15:8] = b;
         3'd2: gw[23:16] = b;
         3'd3: gw[31:24] = b;
         3'd4: gw[39:32] = b;
         3'd5: gw[47:40] = b;
         3'd6: gw[55:48] = b;
         default: gw[63:56] = b;
      endcase
   end

   always_comb begin
      case (field_count_ff[2:0])
         3'd0: expb = csd_pkg::MAGIC[7:0];
         3'd1: expb = csd_pkg::MAGIC[15:8];
         3'd2: expb = csd_pkg::MAGIC[23:16];
         3'd3: expb = csd_pkg::MAGIC[31:24];
         3'd4: expb = cfg.protocol_version[7:0];
         3'd5: expb = cfg.protocol_version[15:8];
         default: expb = {6'd0, cfg.frame_kind};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      field_count_in = field_count_ff;
      field_length_in = field_length_ff;
      word_in = word_ff;
      sidx_in = sidx_ff;
      corrupt_in = corrupt_ff;
      invalid_in = invalid_ff;
      emit = 1'b0;
      code = csd_pkg::FC_NONE;
      val = 64'd0;
      ok = 1'b1;
      lim = (sidx_ff == 2'd3) ? cfg.max_kind_length : cfg.max_id_length;
      count_over_in = count_over_ff;
      frame_count_in = frame_count_ff;
      if (frame_count_ff == CNT_MAX) count_over_in = 1'b1;
      else frame_count_in = frame_count_ff + 1'b1;

      case (phase_ff)
         csd_pkg::PH_PREFIX: begin
            ok = (b == expb);
            if (field_count_ff[2:0] == 3'd6)
               ok = ok && (cfg.frame_kind == csd_pkg::KIND_COMMAND ||
                           cfg.frame_kind == csd_pkg::KIND_SNAPSHOT);
            field_count_in = fc1;
            if (!ok) begin
               corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
            end else if (field_count_ff[2:0] == 3'd6) begin
               phase_in = (cfg.frame_kind == csd_pkg::KIND_SNAPSHOT) ?
                          csd_pkg::PH_REV : csd_pkg::PH_SLEN;
               field_count_in = '0; word_in = '0;
            end
         end
         csd_pkg::PH_SLEN: begin
            word_in = gw; field_count_in = fc1;
            if (field_count_ff[0]) begin
               if (gw[15:0] == 16'd0) begin
                  corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
               end else begin
                  if (gw[15:0] > lim) invalid_in = 1'b1;
                  field_length_in = COUNT_BITS'(gw[15:0]);
                  phase_in = csd_pkg::PH_SBODY;
                  field_count_in = '0; word_in = '0;
               end
            end
         end
         csd_pkg::PH_SBODY: begin
            emit = 1'b1; code = {2'd0, sidx_ff}; val = {56'd0, b};
            field_count_in = fc1;
            if (fc1 >= field_length_ff) begin
               field_count_in = '0; word_in = '0;
               if (sidx_ff == 2'd3) phase_in = csd_pkg::PH_SEQ;
               else begin
                  sidx_in = sidx_ff + 1'b1; phase_in = csd_pkg::PH_SLEN;
               end
            end
         end
         csd_pkg::PH_SEQ, csd_pkg::PH_TICK: begin
            word_in = gw; field_count_in = fc1;
            if (field_count_ff[2:0] == 3'd7) begin
               emit = 1'b1; val = gw;
               code = (phase_ff == csd_pkg::PH_SEQ) ? csd_pkg::FC_SEQ : csd_pkg::FC_TICK;
               phase_in = (phase_ff == csd_pkg::PH_SEQ) ? csd_pkg::PH_TICK
                                                        : csd_pkg::PH_PLEN;
               field_count_in = '0; word_in = '0;
            end
         end
         csd_pkg::PH_PLEN: begin
            word_in = gw; field_count_in = fc1;
            if (field_count_ff[0]) begin
               field_count_in = '0; word_in = '0;
               if (gw[15:0] > cfg.max_payload_bytes) begin
                  corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
               end else if (gw[15:0] == 16'd0) phase_in = csd_pkg::PH_DONE;
               else begin
                  field_length_in = COUNT_BITS'(gw[15:0]);
                  phase_in = csd_pkg::PH_PAYLOAD;
               end
            end
         end
         csd_pkg::PH_PAYLOAD, csd_pkg::PH_STATE: begin
            emit = 1'b1; val = {56'd0, b};
            code = (phase_ff == csd_pkg::PH_PAYLOAD) ? csd_pkg::FC_PAYLOAD
                                                     : csd_pkg::FC_STATE;
            field_count_in = fc1;
            if (fc1 >= field_length_ff) begin
               phase_in = csd_pkg::PH_DONE; field_count_in = '0; word_in = '0;
            end
         end
         csd_pkg::PH_REV: begin
            word_in = gw; field_count_in = fc1;
            if (field_count_ff[2:0] == 3'd7) begin
               if (gw == 64'd0) begin
                  corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
               end else begin
                  emit = 1'b1; code = csd_pkg::FC_REV; val = gw;
                  phase_in = csd_pkg::PH_STLEN;
                  field_count_in = '0; word_in = '0;
               end
            end
         end
         csd_pkg::PH_STLEN: begin
            word_in = gw; field_count_in = fc1;
            if (field_count_ff[1:0] == 2'd3) begin
               if (gw[31:0] == 32'd0 || gw[31:0] > {8'd0, cfg.max_snapshot_bytes}) begin
                  corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
               end else begin
                  field_length_in = (gw[31:0] > 32'(CNT_MAX)) ? CNT_MAX
                                    : COUNT_BITS'(gw[31:0]);
                  phase_in = csd_pkg::PH_STATE;
                  field_count_in = '0; word_in = '0;
               end
            end
         end
         csd_pkg::PH_DONE: begin
            corrupt_in = 1'b1; phase_in = csd_pkg::PH_BAD;
         end
         default: ;
      endcase

      limit = (cfg.frame_kind == csd_pkg::KIND_SNAPSHOT) ?
              {1'b0, cfg.max_snapshot_bytes} + 25'(csd_pkg::SNAP_OVERHEAD) :
              {1'b0, cfg.max_frame_bytes};
      if (count_over_in || {{(33-COUNT_BITS){1'b0}}, frame_count_in} > 33'(limit))
         st = csd_pkg::ST_SIZE;
      else if (corrupt_in || phase_in != csd_pkg::PH_DONE) st = csd_pkg::ST_CORRUPT;
      else if (invalid_in) st = csd_pkg::ST_INVALID;
      else st = csd_pkg::ST_OK;

      out_valid = in_valid && (emit || in_req.frame_end);
      out_rsp.field_code = emit ? code : csd_pkg::FC_NONE;
      out_rsp.value = emit ? val : 64'd0;
      out_rsp.is_final = in_req.frame_end;
      out_rsp.status = in_req.frame_end ? st : csd_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset || (in_valid && in_req.frame_end)) begin
         phase_ff <= csd_pkg::PH_PREFIX;
         frame_count_ff <= '0; count_over_ff <= 1'b0;
         field_count_ff <= '0; field_length_ff <= '0; word_ff <= '0;
         sidx_ff <= '0; corrupt_ff <= 1'b0; invalid_ff <= 1'b0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         frame_count_ff <= frame_count_in; count_over_ff <= count_over_in;
         field_count_ff <= field_count_in; field_length_ff <= field_length_in;
         word_ff <= word_in; sidx_ff <= sidx_in;
         corrupt_ff <= corrupt_in; invalid_ff <= invalid_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/csd_queue.sv -----
// Small result queue between parser and output port.
// Depends on csd_pkg.
`default_nettype none
module csd_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  csd_pkg::rsp_type   wr_data,
   output logic               full,
   input  wire logic          rd_en,
   output csd_pkg::rsp_type   rd_data,
   output logic               empty
);
   csd_pkg::rsp_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic do_wr, do_rd;

   assign full = cnt_ff[2];
   assign empty = (cnt_ff == 3'd0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= wp_ff + 1'b1;
         if (do_rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {2'd0, do_wr} - {2'd0, do_rd};
      end
   end
endmodule
`default_nettype wire

// ----- src/command_snapshot_deframer_core.sv -----
// Command/snapshot deframer top level: CSR block, byte parser, result queue.
// A result is registered in the queue as its byte is taken and reaches the rsp_
// ports once earlier results are popped. Throughput: one byte per cycle while
// req_full is low; req_full is high whenever the queue holds 4 results, set by the queue depth only.
// Reset: synchronous; registers return to defaults, parser to frame start,
// queue empties.
`default_nettype none
module command_snapshot_deframer_core #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  csd_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output csd_pkg::rsp_type  rsp_data,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   csd_pkg::cfg_type cfg;
   csd_pkg::rsp_type f_rsp;
   logic f_valid, q_full, q_empty;

   csd_csr u_csr (.clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
                  .prdata, .pready, .cfg);

   assign req_full = q_full;

   csd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock, .reset, .in_valid(req_push && !q_full), .in_req(req_data), .cfg,
      .out_valid(f_valid), .out_rsp(f_rsp));

   csd_queue u_queue (.clock, .reset, .wr_en(f_valid),
                      .wr_data(f_rsp), .full(q_full), .rd_en(rsp_pop),
                      .rd_data(rsp_data), .empty(q_empty));

   assign rsp_empty = q_empty;
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for command_snapshot_deframer_core: byte frames in, tagged fields out.
// Holds its own frame parser as predictor; depends on csd_pkg and the core RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned CNT_LIMIT = (64'd1 << 24) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   csd_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   csd_pkg::rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   command_snapshot_deframer_core uut (.*);

   always #5 clock = ~clock;

   csd_pkg::req_type pending_items[$];
   csd_pkg::rsp_type expected_fields[$];
   logic [7:0] frame_buf[$];
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   bit push_taken = 1'b0;
   bit failed = 1'b0;

   // predictor copy of the registers and parser state
   logic [1:0] cfg_kind;
   logic [15:0] cfg_version, cfg_max_id, cfg_max_kind, cfg_max_payload;
   logic [23:0] cfg_max_frame, cfg_max_snap;
   csd_pkg::phase_type parse_phase;
   longint unsigned byte_count, field_count, field_length, field_word;
   bit count_over, corrupt_seen, invalid_seen;
   int string_sel;

   function automatic void clear_frame();
      parse_phase = csd_pkg::PH_PREFIX;
      byte_count = 0;
      count_over = 0;
      field_count = 0;
      field_length = 0;
      field_word = 0;
      string_sel = 0;
      corrupt_seen = 0;
      invalid_seen = 0;
   endfunction

   function automatic void mark_corrupt();
      corrupt_seen = 1;
      parse_phase = csd_pkg::PH_BAD;
   endfunction

   function automatic void enter_field(csd_pkg::phase_type p);
      parse_phase = p;
      field_count = 0;
      field_word = 0;
   endfunction

   function automatic bit collect(logic [7:0] b, int n);
      field_word |= longint'(b) << (8 * (field_count & 7));
      field_count++;
      return field_count >= n;
   endfunction

   function automatic void parse_byte(input csd_pkg::req_type r, output bit got,
                                      output csd_pkg::rsp_type o);
      bit emit, ok;
      logic [3:0] code;
      logic [63:0] val;
      logic [7:0] b;
      longint unsigned lim;
      logic [1:0] st;
      b = r.data_byte;
      emit = 0;
      code = csd_pkg::FC_NONE;
      val = '0;
      if (byte_count >= CNT_LIMIT) count_over = 1;
      else byte_count++;
      case (parse_phase)
         csd_pkg::PH_PREFIX: begin
            if (field_count < 4) ok = (b == csd_pkg::MAGIC[8*field_count +: 8]);
            else if (field_count == 4) ok = (b == cfg_version[7:0]);
            else if (field_count == 5) ok = (b == cfg_version[15:8]);
            else ok = (cfg_kind == csd_pkg::KIND_COMMAND ||
                       cfg_kind == csd_pkg::KIND_SNAPSHOT) && b == {6'b0, cfg_kind};
            field_count++;
            if (!ok) mark_corrupt();
            else if (field_count >= 7)
               enter_field(cfg_kind == csd_pkg::KIND_SNAPSHOT ? csd_pkg::PH_REV
                                                               : csd_pkg::PH_SLEN);
         end
         csd_pkg::PH_SLEN: begin
            if (collect(b, 2)) begin
               if (field_word == 0) mark_corrupt();
               else begin
                  if (field_word > ((string_sel == 3) ? cfg_max_kind : cfg_max_id))
                     invalid_seen = 1;
                  field_length = field_word;
                  enter_field(csd_pkg::PH_SBODY);
               end
            end
         end
         csd_pkg::PH_SBODY: begin
            emit = 1;
            code = csd_pkg::FC_PLAYER + 4'(string_sel);
            val = b;
            field_count++;
            if (field_count >= field_length) begin
               if (string_sel >= 3) enter_field(csd_pkg::PH_SEQ);
               else begin
                  string_sel++;
                  enter_field(csd_pkg::PH_SLEN);
               end
            end
         end
         csd_pkg::PH_SEQ, csd_pkg::PH_TICK: begin
            if (collect(b, 8)) begin
               emit = 1;
               code = (parse_phase == csd_pkg::PH_SEQ) ? csd_pkg::FC_SEQ : csd_pkg::FC_TICK;
               val = field_word;
               enter_field(parse_phase == csd_pkg::PH_SEQ ? csd_pkg::PH_TICK
                                                          : csd_pkg::PH_PLEN);
            end
         end
         csd_pkg::PH_PLEN: begin
            if (collect(b, 2)) begin
               if (field_word > cfg_max_payload) mark_corrupt();
               else if (field_word == 0) enter_field(csd_pkg::PH_DONE);
               else begin
                  field_length = field_word;
                  enter_field(csd_pkg::PH_PAYLOAD);
               end
            end
         end
         csd_pkg::PH_PAYLOAD, csd_pkg::PH_STATE: begin
            emit = 1;
            code = (parse_phase == csd_pkg::PH_PAYLOAD) ? csd_pkg::FC_PAYLOAD
                                                        : csd_pkg::FC_STATE;
            val = b;
            field_count++;
            if (field_count >= field_length) enter_field(csd_pkg::PH_DONE);
         end
         csd_pkg::PH_REV: begin
            if (collect(b, 8)) begin
               if (field_word == 0) mark_corrupt();
               else begin
                  emit = 1;
                  code = csd_pkg::FC_REV;
                  val = field_word;
                  enter_field(csd_pkg::PH_STLEN);
               end
            end
         end
         csd_pkg::PH_STLEN: begin
            if (collect(b, 4)) begin
               if (field_word == 0 || field_word > cfg_max_snap) mark_corrupt();
               else begin
                  field_length = (field_word > CNT_LIMIT) ? CNT_LIMIT : field_word;
                  enter_field(csd_pkg::PH_STATE);
               end
            end
         end
         csd_pkg::PH_DONE: mark_corrupt();
         default: ;
      endcase
      if (r.frame_end) begin
         lim = (cfg_kind == csd_pkg::KIND_SNAPSHOT) ?
               longint'(cfg_max_snap) + csd_pkg::SNAP_OVERHEAD : longint'(cfg_max_frame);
         if (count_over || byte_count > lim) st = csd_pkg::ST_SIZE;
         else if (corrupt_seen || parse_phase != csd_pkg::PH_DONE) st = csd_pkg::ST_CORRUPT;
         else if (invalid_seen) st = csd_pkg::ST_INVALID;
         else st = csd_pkg::ST_OK;
         o = '{field_code: emit ? code : csd_pkg::FC_NONE, value: emit ? val : 64'd0,
               is_final: 1'b1, status: st};
         got = 1;
         clear_frame();
      end else begin
         o = '{field_code: code, value: val, is_final: 1'b0, status: csd_pkg::ST_OK};
         got = emit;
      end
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_push || push_taken) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_items.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      bit got;
      csd_pkg::rsp_type exp_rsp;
      push_taken = req_push && !req_full && !reset;
      if (push_taken) begin
         parse_byte(req_data, got, exp_rsp);
         if (got) expected_fields.insert(expected_fields.size(), exp_rsp);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_fields.size() == 0) begin
            $error("unexpected item: field_code %0d value %h", rsp_data.field_code,
                   rsp_data.value);
            failed = 1;
         end else begin
            exp_rsp = expected_fields.pop_front();
            if (rsp_data.field_code !== exp_rsp.field_code) begin
               $error("field_code expected %0d actual %0d", exp_rsp.field_code,
                      rsp_data.field_code);
               failed = 1;
            end
            if (rsp_data.value !== exp_rsp.value) begin
               $error("value expected %h actual %h", exp_rsp.value, rsp_data.value);
               failed = 1;
            end
            if (rsp_data.is_final !== exp_rsp.is_final) begin
               $error("is_final expected %0d actual %0d", exp_rsp.is_final,
                      rsp_data.is_final);
               failed = 1;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status expected %0d actual %0d", exp_rsp.status, rsp_data.status);
               failed = 1;
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         csd_pkg::REG_KIND: cfg_kind = val[1:0];
         csd_pkg::REG_VERSION: cfg_version = val[15:0];
         csd_pkg::REG_MAX_FRAME: cfg_max_frame = val[23:0];
         csd_pkg::REG_MAX_ID: cfg_max_id = val[15:0];
         csd_pkg::REG_MAX_KIND: cfg_max_kind = val[15:0];
         csd_pkg::REG_MAX_PAYLOAD: cfg_max_payload = val[15:0];
         csd_pkg::REG_MAX_SNAP: cfg_max_snap = val[23:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic void put_byte(logic [7:0] v);
      frame_buf.insert(frame_buf.size(), v);
   endfunction

   function automatic void put_le(longint unsigned v, int n);
      for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
   endfunction

   function automatic void put_prefix(logic [7:0] kind_byte);
      put_le(csd_pkg::MAGIC, 4);
      put_le(cfg_version, 2);
      put_byte(kind_byte);
   endfunction

   function automatic void put_string(int len);
      put_le(len, 2);
      for (int i = 0; i < len; i++) put_byte(8'($urandom));
   endfunction

   function automatic void command_frame(int l0, int l1, int l2, int l3, int plen,
                                         logic [63:0] seq, logic [63:0] tick);
      put_prefix(csd_pkg::KIND_COMMAND);
      put_string(l0);
      put_string(l1);
      put_string(l2);
      put_string(l3);
      put_le(seq, 8);
      put_le(tick, 8);
      put_string(plen);
   endfunction

   function automatic void snapshot_frame(logic [63:0] rev, int slen);
      put_prefix(csd_pkg::KIND_SNAPSHOT);
      put_le(rev, 8);
      put_le(slen, 4);
      for (int i = 0; i < slen; i++) put_byte(8'($urandom));
   endfunction

   function automatic int commit_frame();
      int n;
      n = frame_buf.size();
      for (int i = 0; i < n; i++)
         pending_items.insert(pending_items.size(),
                              '{data_byte: frame_buf[i], frame_end: i == n - 1});
      frame_buf.delete();
      return n;
   endfunction

   function automatic int pick_len(int lim);
      if (lim < 40 && $urandom_range(9) == 0) return lim + 1;
      return $urandom_range(1, 4);
   endfunction

   function automatic int random_frame();
      int n;
      if ($urandom_range(99) < 10) begin
         n = $urandom_range(1, 12);
         repeat (n) put_byte(8'($urandom));
         return commit_frame();
      end
      if (cfg_kind == csd_pkg::KIND_SNAPSHOT)
         snapshot_frame($urandom_range(19) == 0 ? 64'd0 : {$urandom, $urandom},
                        $urandom_range(19) == 0 ? 0 :
                        (cfg_max_snap < 20 && $urandom_range(7) == 0) ? cfg_max_snap + 1 :
                        $urandom_range(1, 6));
      else
         command_frame(pick_len(cfg_max_id), pick_len(cfg_max_id), pick_len(cfg_max_id),
                       pick_len(cfg_max_kind),
                       (cfg_max_payload < 20 && $urandom_range(7) == 0) ?
                          cfg_max_payload + 1 : $urandom_range(0, 6),
                       {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(2))
            0: begin
               n = $urandom_range(frame_buf.size() - 1);
               frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
            end
            1: begin
               n = $urandom_range(1, frame_buf.size() - 1);
               while (frame_buf.size() > n) void'(frame_buf.pop_back());
            end
            default: repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
         endcase
      end
      return commit_frame();
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || req_push || expected_fields.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic run_phase(logic [1:0] kind, logic [15:0] ver, logic [23:0] max_frame,
                            logic [15:0] max_id, logic [15:0] max_kind,
                            logic [15:0] max_pay, logic [23:0] max_snap,
                            int s_idle, int r_stall, int nbytes);
      int sent;
      csr_write(csd_pkg::REG_KIND, kind);
      csr_write(csd_pkg::REG_VERSION, ver);
      csr_write(csd_pkg::REG_MAX_FRAME, max_frame);
      csr_write(csd_pkg::REG_MAX_ID, max_id);
      csr_write(csd_pkg::REG_MAX_KIND, max_kind);
      csr_write(csd_pkg::REG_MAX_PAYLOAD, max_pay);
      csr_write(csd_pkg::REG_MAX_SNAP, max_snap);
      send_idle_pct = s_idle;
      pop_stall_pct = r_stall;
      sent = 0;
      while (sent < nbytes) sent += random_frame();
      drain();
   endtask

   initial begin
      int unused;
      cfg_kind = csd_pkg::KIND_COMMAND;
      cfg_version = 16'd1;
      cfg_max_frame = 24'd4096;
      cfg_max_id = 16'd64;
      cfg_max_kind = 16'd64;
      cfg_max_payload = 16'd1024;
      cfg_max_snap = 24'd1048576;
      clear_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      command_frame(1, 2, 1, 3, 2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      unused = commit_frame();
      command_frame(1, 1, 1, 1, 0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      unused = commit_frame();
      command_frame(1, 0, 1, 1, 0, 64'd5, 64'd6);
      unused = commit_frame();
      command_frame(65, 1, 1, 65, 1, 64'd1, 64'd2);
      unused = commit_frame();
      put_prefix(csd_pkg::KIND_COMMAND);
      repeat (4) put_string(1);
      put_le(0, 16);
      put_le(1025, 2);
      unused = commit_frame();
      put_prefix(csd_pkg::KIND_SNAPSHOT);
      unused = commit_frame();
      drain();

      run_phase(csd_pkg::KIND_COMMAND, 16'd0, 24'hFFFFFF, 16'd1, 16'hFFFF, 16'd0, 24'd1,
                0, 0, 180);
      run_phase(csd_pkg::KIND_SNAPSHOT, 16'hFFFF, 24'd4096, 16'd64, 16'd64, 16'd1024,
                24'd16777183, 59, 0, 180);
      run_phase(csd_pkg::KIND_COMMAND, 16'h1234, 24'd60, 16'd3, 16'd3, 16'd5, 24'd100,
                0, 59, 180);
      run_phase(csd_pkg::KIND_SNAPSHOT, 16'd7, 24'd4096, 16'd64, 16'd64, 16'd1024, 24'd4,
                22, 22, 180);
      run_phase(2'd3, 16'd1, 24'd1, 16'd64, 16'd64, 16'd1024, 24'd100, 0, 0, 100);
      run_phase(csd_pkg::KIND_COMMAND, 16'd1, 24'd4096, 16'd64, 16'd64, 16'hFFFF,
                24'd1048576, 22, 22, 180);

      if (!failed) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
